>>> hw/rtl/cmrq_pkg.sv
// ---------------------------------------------------------------------------
// cmrq_pkg
// Shared types, constants and helpers for the coalescing message ring queue.
// ---------------------------------------------------------------------------
package cmrq_pkg;

	localparam int QUEUE_DEPTH = 8;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);

	localparam int KIND_W    = 16;
	localparam int PARAM_W   = 16;
	localparam int PAYLOAD_W = 32;
	localparam int KEY_W     = KIND_W + PARAM_W;
	localparam int ENTRY_W   = KEY_W + PAYLOAD_W;

	localparam logic ACT_POST = 1'b0;
	localparam logic ACT_POP  = 1'b1;

	typedef logic [PTR_W-1:0] ptr_t;

	// result register update selected by the controller
	typedef enum logic [2:0] {
		RES_NONE,
		RES_FAIL,
		RES_OK_POST,
		RES_ABSORB,
		RES_POP
	} res_op_t;

	typedef struct packed {
		logic    capture;  // latch the accepted word
		logic    rd_head;  // read entry at read pointer, scan pointer to the next one
		logic    rd_scan;  // read entry at scan pointer, advance scan pointer
		logic    push;     // write held word at tail, advance write pointer
		logic    pop;      // advance read pointer
		res_op_t res;
	} cmrq_cmd_t;

	typedef struct packed {
		logic is_pop;
		logic empty;
		logic full;
		logic timer_hit;  // held kind equals timer kind
		logic key_hit;    // read entry matches held key
		logic scan_end;   // scan pointer reached write pointer
		logic out_free;
	} cmrq_sts_t;

	// wrap at the depth so non power of two depths work
	function automatic ptr_t ptr_adv(input ptr_t p);
		ptr_t r;
		if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + PTR_W'(1);
		end
		return r;
	endfunction

endpackage

>>> hw/rtl/cmrq_in_if.sv
// ---------------------------------------------------------------------------
// cmrq_in_if
// Request channel: post or pop command with message fields.
// ---------------------------------------------------------------------------
interface cmrq_in_if;
	logic                           valid;
	logic                           ready;
	logic                           action;
	logic [cmrq_pkg::KIND_W-1:0]    msg_kind;
	logic [cmrq_pkg::PARAM_W-1:0]   msg_param;
	logic [cmrq_pkg::PAYLOAD_W-1:0] msg_payload;

	modport source (output valid, action, msg_kind, msg_param, msg_payload, input ready);
	modport sink   (input valid, action, msg_kind, msg_param, msg_payload, output ready);
endinterface

>>> hw/rtl/cmrq_out_if.sv
// ---------------------------------------------------------------------------
// cmrq_out_if
// Response channel: status and popped message.
// ---------------------------------------------------------------------------
interface cmrq_out_if;
	logic                           valid;
	logic                           ready;
	logic                           ok;
	logic                           absorbed;
	logic [cmrq_pkg::KIND_W-1:0]    out_kind;
	logic [cmrq_pkg::PARAM_W-1:0]   out_param;
	logic [cmrq_pkg::PAYLOAD_W-1:0] out_payload;

	modport source (output valid, ok, absorbed, out_kind, out_param, out_payload, input ready);
	modport sink   (input valid, ok, absorbed, out_kind, out_param, out_payload, output ready);
endinterface

>>> hw/rtl/coalescing_message_ring_queue_unit.sv
// ---------------------------------------------------------------------------
// coalescing_message_ring_queue_unit
// Ring queue of messages with coalescing of duplicate timer posts.
// ---------------------------------------------------------------------------
// Request channel req carries a post (action 0) or pop (action 1); each
// request word yields exactly one word on the response channel rsp.
// The ring holds QUEUE_DEPTH - 1 messages. A post to a full ring returns
// ok 0. A post whose kind equals the timer kind register is compared with
// every queued entry on kind and param; a match returns ok 1, absorbed 1
// and stores nothing. A pop returns the head message, or ok 0 when empty.
// A plain post or a refused request is answered from the held word; a pop
// first reads the head entry through the registered read port; a timer
// post compares 1 to QUEUE_DEPTH - 2 entries, head first, stopping at a
// match or at the tail, with one store read per entry through the single
// read port. No new request is taken until the last result is registered.
// The response sits in an output register; a new request is still taken
// while it waits, and its processing holds until that register is free.
// Reset empties the ring and clears the timer kind to 0; stored messages
// are not cleared. The timer kind is written through cfg_we/cfg_wdata; the
// user must write it only while no request is in progress; the block does not enforce this.
// ---------------------------------------------------------------------------
module coalescing_message_ring_queue_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [cmrq_pkg::KIND_W-1:0] cfg_wdata,
	cmrq_in_if.sink                     req,
	cmrq_out_if.source                  rsp
);

	cmrq_pkg::cmrq_cmd_t cmd;
	cmrq_pkg::cmrq_sts_t sts;
	logic                in_ready;

	assign req.ready = in_ready;

	cmrq_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(req.valid),
		.in_ready(in_ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	cmrq_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.action     (req.action),
		.msg_kind   (req.msg_kind),
		.msg_param  (req.msg_param),
		.msg_payload(req.msg_payload),
		.cmd        (cmd),
		.sts        (sts),
		.rsp        (rsp)
	);

endmodule

>>> hw/rtl/cmrq_ram.sv
// ---------------------------------------------------------------------------
// cmrq_ram
// Generic simple dual port RAM, one write port, one registered read port.
// ---------------------------------------------------------------------------
module cmrq_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> hw/rtl/cmrq_datapath.sv
// ---------------------------------------------------------------------------
// cmrq_datapath
// Held request, ring pointers, message store, key compare and result register.
// ---------------------------------------------------------------------------
module cmrq_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [cmrq_pkg::KIND_W-1:0]    cfg_wdata,
	input  logic                           action,
	input  logic [cmrq_pkg::KIND_W-1:0]    msg_kind,
	input  logic [cmrq_pkg::PARAM_W-1:0]   msg_param,
	input  logic [cmrq_pkg::PAYLOAD_W-1:0] msg_payload,
	input  cmrq_pkg::cmrq_cmd_t            cmd,
	output cmrq_pkg::cmrq_sts_t            sts,
	cmrq_out_if.source                     rsp
);

	logic                           action_q;
	logic [cmrq_pkg::KIND_W-1:0]    kind_q;
	logic [cmrq_pkg::PARAM_W-1:0]   param_q;
	logic [cmrq_pkg::PAYLOAD_W-1:0] payload_q;
	logic [cmrq_pkg::KIND_W-1:0]    timer_kind_q;
	cmrq_pkg::ptr_t                 rd_ptr_q;
	cmrq_pkg::ptr_t                 wr_ptr_q;
	cmrq_pkg::ptr_t                 scan_ptr_q;

	logic                           rsp_vld_q;
	logic                           ok_q;
	logic                           absorbed_q;
	logic [cmrq_pkg::KIND_W-1:0]    out_kind_q;
	logic [cmrq_pkg::PARAM_W-1:0]   out_param_q;
	logic [cmrq_pkg::PAYLOAD_W-1:0] out_payload_q;

	logic                           ram_re;
	cmrq_pkg::ptr_t                 ram_raddr;
	logic [cmrq_pkg::ENTRY_W-1:0]   ram_rdata;

	// entry layout: payload | param | kind
	cmrq_ram #(
		.WIDTH(cmrq_pkg::ENTRY_W),
		.DEPTH(cmrq_pkg::QUEUE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (cmd.push),
		.waddr(wr_ptr_q),
		.wdata({payload_q, param_q, kind_q}),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign ram_re    = cmd.rd_head | cmd.rd_scan;
	assign ram_raddr = cmd.rd_head ? rd_ptr_q : scan_ptr_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			action_q  <= action;
			kind_q    <= msg_kind;
			param_q   <= msg_param;
			payload_q <= msg_payload;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timer_kind_q <= '0;
			rd_ptr_q     <= '0;
			wr_ptr_q     <= '0;
			scan_ptr_q   <= '0;
		end else begin
			if (cfg_we) begin
				timer_kind_q <= cfg_wdata;
			end
			if (cmd.push) begin
				wr_ptr_q <= cmrq_pkg::ptr_adv(wr_ptr_q);
			end
			if (cmd.pop) begin
				rd_ptr_q <= cmrq_pkg::ptr_adv(rd_ptr_q);
			end
			if (cmd.rd_head) begin
				scan_ptr_q <= cmrq_pkg::ptr_adv(rd_ptr_q);
			end else if (cmd.rd_scan) begin
				scan_ptr_q <= cmrq_pkg::ptr_adv(scan_ptr_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (cmd.res != cmrq_pkg::RES_NONE) begin
			rsp_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.res) inside
			cmrq_pkg::RES_FAIL, cmrq_pkg::RES_OK_POST, cmrq_pkg::RES_ABSORB: begin
				ok_q          <= (cmd.res != cmrq_pkg::RES_FAIL);
				absorbed_q    <= (cmd.res == cmrq_pkg::RES_ABSORB);
				out_kind_q    <= '0;
				out_param_q   <= '0;
				out_payload_q <= '0;
			end
			cmrq_pkg::RES_POP: begin
				ok_q          <= 1'b1;
				absorbed_q    <= 1'b0;
				out_kind_q    <= ram_rdata[cmrq_pkg::KIND_W-1:0];
				out_param_q   <= ram_rdata[cmrq_pkg::KEY_W-1:cmrq_pkg::KIND_W];
				out_payload_q <= ram_rdata[cmrq_pkg::ENTRY_W-1:cmrq_pkg::KEY_W];
			end
			default: begin
			end
		endcase
	end

	assign rsp.valid       = rsp_vld_q;
	assign rsp.ok          = ok_q;
	assign rsp.absorbed    = absorbed_q;
	assign rsp.out_kind    = out_kind_q;
	assign rsp.out_param   = out_param_q;
	assign rsp.out_payload = out_payload_q;

	assign sts.is_pop    = (action_q == cmrq_pkg::ACT_POP);
	assign sts.empty     = (rd_ptr_q == wr_ptr_q);
	assign sts.full      = (cmrq_pkg::ptr_adv(wr_ptr_q) == rd_ptr_q);
	assign sts.timer_hit = (kind_q == timer_kind_q);
	assign sts.key_hit   = (ram_rdata[cmrq_pkg::KEY_W-1:0] == {param_q, kind_q});
	assign sts.scan_end  = (scan_ptr_q == wr_ptr_q);
	assign sts.out_free  = !rsp_vld_q || rsp.ready;

`ifndef SYNTHESIS
	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> !sts.full) else $error("push into full ring");
	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> !sts.empty) else $error("pop from empty ring");
	a_absorb_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_vld_q && absorbed_q) |-> ok_q) else $error("absorbed without ok");
	a_rd_range: assert property (@(posedge clk) disable iff (!arst_n)
		rd_ptr_q <= cmrq_pkg::PTR_W'(cmrq_pkg::QUEUE_DEPTH - 1))
		else $error("read pointer out of range");
`endif

endmodule

>>> hw/rtl/cmrq_ctrl.sv
// ---------------------------------------------------------------------------
// cmrq_ctrl
// Sequencer: decides post/pop handling and steps the duplicate scan.
// ---------------------------------------------------------------------------
module cmrq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  cmrq_pkg::cmrq_sts_t sts,
	output cmrq_pkg::cmrq_cmd_t cmd
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_EVAL = 4'b0010,
		ST_SCAN = 4'b0100,
		ST_POP  = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.res     = cmrq_pkg::RES_NONE;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_EVAL;
				end
			end
			// results load straight into the output register, so wait for it here
			ST_EVAL: begin
				if (sts.out_free) begin
					if (sts.is_pop) begin
						if (sts.empty) begin
							cmd.res = cmrq_pkg::RES_FAIL;
							state_d = ST_IDLE;
						end else begin
							cmd.rd_head = 1'b1;
							state_d     = ST_POP;
						end
					end else if (sts.full) begin
						cmd.res = cmrq_pkg::RES_FAIL;
						state_d = ST_IDLE;
					end else if (sts.timer_hit && !sts.empty) begin
						cmd.rd_head = 1'b1;
						state_d     = ST_SCAN;
					end else begin
						cmd.push = 1'b1;
						cmd.res  = cmrq_pkg::RES_OK_POST;
						state_d  = ST_IDLE;
					end
				end
			end
			ST_SCAN: begin
				if (sts.key_hit) begin
					cmd.res = cmrq_pkg::RES_ABSORB;
					state_d = ST_IDLE;
				end else if (sts.scan_end) begin
					cmd.push = 1'b1;
					cmd.res  = cmrq_pkg::RES_OK_POST;
					state_d  = ST_IDLE;
				end else begin
					cmd.rd_scan = 1'b1;
				end
			end
			ST_POP: begin
				cmd.pop = 1'b1;
				cmd.res = cmrq_pkg::RES_POP;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef SYNTHESIS
	a_res_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.res != cmrq_pkg::RES_NONE) |-> sts.out_free)
		else $error("result loaded over pending word");
	a_pop_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_POP) |-> $past(cmd.rd_head)) else $error("pop without head read");
	a_scan_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> ($past(cmd.rd_head) || $past(cmd.rd_scan)))
		else $error("scan compare without read");
`endif

endmodule

>>> tb/tb_coalescing_message_ring_queue_unit.sv
// ---------------------------------------------------------------------------
// tb_coalescing_message_ring_queue_unit
// Self-checking bench for the coalescing message ring queue. A scoreboard
// class tracks the ring contents, pointers and timer kind, predicts the
// response to every accepted request word and checks the response words in
// order. Directed posts and pops cover empty, full, wrap and coalescing;
// random traffic alternates fill and drain bursts under several timer
// kinds, mostly with random idling on both channels, and a long hold-off.
// ---------------------------------------------------------------------------
module tb_coalescing_message_ring_queue_unit;
	import cmrq_pkg::*;

	typedef struct packed {
		logic                 ok;
		logic                 absorbed;
		logic [KIND_W-1:0]    kind;
		logic [PARAM_W-1:0]   param;
		logic [PAYLOAD_W-1:0] payload;
	} reply_t;

	typedef struct packed {
		logic [KIND_W-1:0]    kind;
		logic [PARAM_W-1:0]   param;
		logic [PAYLOAD_W-1:0] payload;
	} msg_t;

	class msg_queue_scoreboard;
		msg_t              ring[QUEUE_DEPTH];
		int                head;
		int                tail;
		logic [KIND_W-1:0] timer_kind;
		reply_t            replies[$];
		int                errors;
		int                n_stored;
		int                n_absorbed;
		int                n_refused;
		int                n_popped;
		int                n_empty;

		function new();
			head = 0;
			tail = 0;
			timer_kind = '0;
			errors = 0;
			n_stored = 0;
			n_absorbed = 0;
			n_refused = 0;
			n_popped = 0;
			n_empty = 0;
		endfunction

		// work out the response to one accepted request word
		function void note_request(input logic act, input logic [KIND_W-1:0] kind,
				input logic [PARAM_W-1:0] param, input logic [PAYLOAD_W-1:0] payload);
			reply_t r;
			int     p;
			bit     hit;
			r = '0;
			hit = 0;
			if (act == ACT_POST) begin
				if ((tail + 1) % QUEUE_DEPTH != head) begin
					r.ok = 1'b1;
					if (kind == timer_kind) begin
						for (p = head; p != tail && !hit; p = (p + 1) % QUEUE_DEPTH)
							hit = (ring[p].kind == kind) && (ring[p].param == param);
					end
					if (hit) begin
						r.absorbed = 1'b1;
						n_absorbed++;
					end else begin
						ring[tail] = '{kind: kind, param: param, payload: payload};
						tail = (tail + 1) % QUEUE_DEPTH;
						n_stored++;
					end
				end else begin
					n_refused++;
				end
			end else begin
				if (head != tail) begin
					r.ok = 1'b1;
					r.kind = ring[head].kind;
					r.param = ring[head].param;
					r.payload = ring[head].payload;
					head = (head + 1) % QUEUE_DEPTH;
					n_popped++;
				end else begin
					n_empty++;
				end
			end
			replies.push_back(r);
		endfunction

		function void check_reply(input reply_t got);
			reply_t want;
			if (replies.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t: unexpected response ok=%b abs=%b kind=%h param=%h pl=%h",
						$time, got.ok, got.absorbed, got.kind, got.param, got.payload);
			end else begin
				want = replies.pop_front();
				if (got.ok !== want.ok || got.absorbed !== want.absorbed ||
						got.kind !== want.kind || got.param !== want.param ||
						got.payload !== want.payload) begin
					errors++;
					if (errors <= 10) begin
						$display("%0t: response mismatch", $time);
						$display("  expected ok=%b abs=%b kind=%h param=%h pl=%h",
							want.ok, want.absorbed, want.kind, want.param, want.payload);
						$display("  actual   ok=%b abs=%b kind=%h param=%h pl=%h",
							got.ok, got.absorbed, got.kind, got.param, got.payload);
					end
				end
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [KIND_W-1:0] cfg_wdata;

	cmrq_in_if  req_if ();
	cmrq_out_if rsp_if ();

	coalescing_message_ring_queue_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.req      (req_if),
		.rsp      (rsp_if)
	);

	msg_queue_scoreboard sb = new();

	bit idle_on;
	bit stall_on;
	int hold_left;
	int n_cfg;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("tb_coalescing_message_ring_queue_unit: FAIL");
		$finish;
	end

	// response side: check on handshake, then decide ready for the next edge
	initial begin
		reply_t got;
		rsp_if.ready <= 1'b1;
		forever begin
			@(posedge clk);
			if (rsp_if.valid && rsp_if.ready) begin
				got = {rsp_if.ok, rsp_if.absorbed, rsp_if.out_kind, rsp_if.out_param,
					rsp_if.out_payload};
				sb.check_reply(got);
			end
			if (hold_left > 0) begin
				rsp_if.ready <= 1'b0;
				hold_left--;
			end else if (stall_on) begin
				rsp_if.ready <= ($urandom_range(0, 99) >= 18);
			end else begin
				rsp_if.ready <= 1'b1;
			end
		end
	end

	task automatic send_word(input logic act, input logic [KIND_W-1:0] kind,
			input logic [PARAM_W-1:0] param, input logic [PAYLOAD_W-1:0] payload);
		while (idle_on && $urandom_range(0, 99) < 18) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.action <= act;
		req_if.msg_kind <= kind;
		req_if.msg_param <= param;
		req_if.msg_payload <= payload;
		@(posedge clk);
		while (!req_if.ready) @(posedge clk);
		sb.note_request(act, kind, param, payload);
	endtask

	task automatic post(input logic [KIND_W-1:0] kind, input logic [PARAM_W-1:0] param,
			input logic [PAYLOAD_W-1:0] payload);
		send_word(ACT_POST, kind, param, payload);
	endtask

	task automatic pop_head();
		send_word(ACT_POP, KIND_W'($urandom), PARAM_W'($urandom), $urandom);
	endtask

	// let every outstanding response land before touching the register
	task automatic settle();
		req_if.valid <= 1'b0;
		while (sb.replies.size() != 0) @(posedge clk);
		repeat (QUEUE_DEPTH + 4) @(posedge clk);
	endtask

	task automatic set_timer_kind(input logic [KIND_W-1:0] k);
		cfg_we <= 1'b1;
		cfg_wdata <= k;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.timer_kind = k;
		n_cfg++;
	endtask

	// alternating fill and drain bursts; keys drawn from a small pool so
	// timer posts often hit queued entries
	task automatic run_traffic(input int count, input int fill_pct);
		logic [KIND_W-1:0]  kind;
		logic [PARAM_W-1:0] param;
		int                 sel;
		int                 pct;
		for (int i = 0; i < count; i++) begin
			pct = ((i / 40) % 2 == 0) ? fill_pct : 100 - fill_pct;
			sel = $urandom_range(0, 99);
			if (sel < 45)
				kind = sb.timer_kind;
			else if (sel < 60)
				kind = KIND_W'($urandom_range(0, 3));
			else
				kind = KIND_W'($urandom);
			if ($urandom_range(0, 99) < 65)
				param = PARAM_W'($urandom_range(0, 3));
			else
				param = PARAM_W'($urandom);
			if ($urandom_range(0, 99) < pct)
				post(kind, param, $urandom);
			else
				pop_head();
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		req_if.valid <= 1'b0;
		req_if.action <= ACT_POST;
		req_if.msg_kind <= '0;
		req_if.msg_param <= '0;
		req_if.msg_payload <= '0;
		idle_on = 1'b1;
		stall_on = 1'b1;
		hold_left = 0;
		n_cfg = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// timer kind left at its reset value of 0
		pop_head();
		post(16'h0000, 16'h0000, 32'h0000_0000);
		post(16'h0000, 16'h0000, 32'hFFFF_FFFF);
		post(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
		post(16'hFFFF, 16'hFFFF, 32'h0000_0000);
		post(16'h0000, 16'hFFFF, 32'h1234_5678);
		post(16'h0001, 16'h0000, 32'h8000_0001);
		post(16'h8000, 16'h8000, 32'h7FFF_FFFE);
		post(16'h5555, 16'hAAAA, 32'hA5A5_5A5A);
		// ring full: duplicate and plain post both refused
		post(16'h0000, 16'h0000, 32'hDEAD_BEEF);
		post(16'h1234, 16'h5678, 32'h0BAD_F00D);
		repeat (7) pop_head();
		pop_head();
		// pointers now near the top: a match across the wrap point
		post(16'h0000, 16'h0002, 32'h0000_0002);
		post(16'h0000, 16'h0003, 32'h0000_0003);
		post(16'h0000, 16'h0003, 32'hFFFF_0003);
		pop_head();
		pop_head();
		settle();

		set_timer_kind(16'hFFFF);
		run_traffic(400, 75);
		settle();

		// long stretch with no idling on either side
		set_timer_kind(KIND_W'($urandom));
		idle_on = 1'b0;
		stall_on = 1'b0;
		run_traffic(400, 70);
		settle();

		// hold the response side while requests keep coming
		idle_on = 1'b1;
		stall_on = 1'b1;
		hold_left = 300;
		repeat (40) post(($urandom_range(0, 1) != 0) ? sb.timer_kind : KIND_W'($urandom),
			PARAM_W'($urandom_range(0, 3)), $urandom);
		repeat (10) pop_head();
		settle();

		set_timer_kind(16'h0000);
		run_traffic(400, 80);
		settle();

		set_timer_kind(KIND_W'($urandom));
		run_traffic(400, 65);
		settle();

		$display("Covered %0d stored, %0d absorbed, %0d refused posts; %0d pops, %0d empty.",
			sb.n_stored, sb.n_absorbed, sb.n_refused, sb.n_popped, sb.n_empty);
		$display("Timer kind written %0d times; %0d mismatches.", n_cfg, sb.errors);
		if (sb.errors == 0 && sb.replies.size() == 0) begin
			$display("tb_coalescing_message_ring_queue_unit: PASS");
		end else begin
			$display("tb_coalescing_message_ring_queue_unit: FAIL");
		end
		$finish;
	end

endmodule

>>> files.f
hw/rtl/cmrq_pkg.sv
hw/rtl/cmrq_in_if.sv
hw/rtl/cmrq_out_if.sv
hw/rtl/cmrq_ram.sv
hw/rtl/cmrq_datapath.sv
hw/rtl/cmrq_ctrl.sv
hw/rtl/coalescing_message_ring_queue_unit.sv
tb/tb_coalescing_message_ring_queue_unit.sv
